@@ rtl/direct_form_iir_biquad_top_macros.svh @@
// Assertion macros for the checker file.
`ifndef DIRECT_FORM_IIR_BIQUAD_TOP_MACROS_SVH
`define DIRECT_FORM_IIR_BIQUAD_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFIB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DFIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dfib_pkg.sv @@
package dfib_pkg;

    localparam int unsigned COEF_W  = 18;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PROD_W  = COEF_W + SAMPLE_W;
    localparam int unsigned ACC_W   = PROD_W + 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned FRAC_BITS = 14;

    localparam logic signed [COEF_W-1:0]   RESET_B0     = 18'sd16384;
    localparam logic signed [COEF_W-1:0]   RESET_GAIN   = 18'sd16384;
    localparam logic signed [PROD_W-1:0]   ROUND_HALF_P = 34'sd8192;
    localparam logic signed [ACC_W-1:0]    ROUND_HALF_A = 38'sd8192;
    localparam logic signed [23:0]         SAT_MAX      = 24'sd32767;
    localparam logic signed [23:0]         SAT_MIN      = -24'sd32768;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd6;

    typedef struct packed {
        logic signed [COEF_W-1:0]   b0;
        logic signed [COEF_W-1:0]   b1;
        logic signed [COEF_W-1:0]   b2;
        logic signed [COEF_W-1:0]   a1;
        logic signed [COEF_W-1:0]   a2;
        logic signed [COEF_W-1:0]   gain;
        logic signed [SAMPLE_W-1:0] level_offset;
    } t_cfg;

    typedef enum logic [2:0] {
        MS_GX,
        MS_B0,
        MS_B1,
        MS_B2,
        MS_A1,
        MS_A2,
        MS_GY
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     prod_en;
        t_acc_op  acc_op;
        logic     clr_ovf;
        logic     scale_in;
        logic     update_hist;
        logic     scale_out;
    } t_dp_cmd;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] val;
        logic                       ovf;
    } t_sat;

    function automatic t_sat sat16(input logic signed [23:0] v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.val = 16'sh7fff;
            r.ovf = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val = 16'sh8000;
            r.ovf = 1'b1;
        end else begin
            r.val = v[SAMPLE_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/dfib_cfg.sv @@
module dfib_cfg
    import dfib_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.b0           <= RESET_B0;
            r_cfg.b1           <= '0;
            r_cfg.b2           <= '0;
            r_cfg.a1           <= '0;
            r_cfg.a2           <= '0;
            r_cfg.gain         <= RESET_GAIN;
            r_cfg.level_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:     r_cfg.b0           <= i_cfg_data;
                REG_B1:     r_cfg.b1           <= i_cfg_data;
                REG_B2:     r_cfg.b2           <= i_cfg_data;
                REG_A1:     r_cfg.a1           <= i_cfg_data;
                REG_A2:     r_cfg.a2           <= i_cfg_data;
                REG_GAIN:   r_cfg.gain         <= i_cfg_data;
                REG_OFFSET: r_cfg.level_offset <= i_cfg_data[SAMPLE_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/dfib_ctrl.sv @@
module dfib_ctrl
    import dfib_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_XS   = 10'b00_0000_0010,
        S_B0   = 10'b00_0000_0100,
        S_B2   = 10'b00_0000_1000,
        S_A1   = 10'b00_0001_0000,
        S_A2   = 10'b00_0010_0000,
        S_LAST = 10'b00_0100_0000,
        S_Y    = 10'b00_1000_0000,
        S_GY   = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_fire;
    logic   w_out_free;

    assign w_in_fire  = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '{mul_sel: MS_GX, prod_en: 1'b0, acc_op: ACC_HOLD, clr_ovf: 1'b0,
                        scale_in: 1'b0, update_hist: 1'b0, scale_out: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_cmd.mul_sel = MS_GX;
                o_cmd.prod_en = w_in_fire;
                o_cmd.clr_ovf = w_in_fire;
                if (w_in_fire) begin
                    n_state = S_XS;
                end
            end
            S_XS: begin
                o_cmd.scale_in = 1'b1;
                o_cmd.mul_sel  = MS_B1;
                o_cmd.prod_en  = 1'b1;
                n_state        = S_B0;
            end
            S_B0: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_sel = MS_B0;
                o_cmd.prod_en = 1'b1;
                n_state       = S_B2;
            end
            S_B2: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MS_B2;
                o_cmd.prod_en = 1'b1;
                n_state       = S_A1;
            end
            S_A1: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MS_A1;
                o_cmd.prod_en = 1'b1;
                n_state       = S_A2;
            end
            S_A2: begin
                o_cmd.acc_op  = ACC_SUB;
                o_cmd.mul_sel = MS_A2;
                o_cmd.prod_en = 1'b1;
                n_state       = S_LAST;
            end
            S_LAST: begin
                o_cmd.acc_op = ACC_SUB;
                n_state      = S_Y;
            end
            S_Y: begin
                o_cmd.update_hist = 1'b1;
                n_state           = S_GY;
            end
            S_GY: begin
                // y1 already holds the new filter output
                o_cmd.mul_sel = MS_GY;
                o_cmd.prod_en = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // hold here until the output register is free
                if (w_out_free) begin
                    o_cmd.scale_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ rtl/dfib_dp.sv @@
module dfib_dp
    import dfib_pkg::*;
#(
    parameter int unsigned TAP_COUNT = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  t_dp_cmd                     i_cmd,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    output logic                        o_overflow
);

    logic signed [COEF_W-1:0]   w_b1, w_b2, w_a1, w_a2;
    logic signed [COEF_W-1:0]   w_mul_c;
    logic signed [SAMPLE_W-1:0] w_mul_d;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_prod_rnd;
    logic signed [20:0]         w_scaled_sum;
    logic signed [ACC_W-1:0]    w_acc_rnd;
    logic signed [ACC_W-1:0]    w_prod_ext;
    t_sat                       w_scaled;
    t_sat                       w_ysat;

    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_xs;
    logic signed [SAMPLE_W-1:0] r_x1, r_x2, r_y1, r_y2;
    logic                       r_ovf;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_out_ovf;

    // taps beyond the configured count contribute nothing
    assign w_b1 = (TAP_COUNT > 1) ? i_cfg.b1 : '0;
    assign w_a1 = (TAP_COUNT > 1) ? i_cfg.a1 : '0;
    assign w_b2 = (TAP_COUNT > 2) ? i_cfg.b2 : '0;
    assign w_a2 = (TAP_COUNT > 2) ? i_cfg.a2 : '0;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_GX: begin w_mul_c = i_cfg.gain; w_mul_d = i_sample_in; end
            MS_B0: begin w_mul_c = i_cfg.b0;   w_mul_d = r_xs;        end
            MS_B1: begin w_mul_c = w_b1;       w_mul_d = r_x1;        end
            MS_B2: begin w_mul_c = w_b2;       w_mul_d = r_x2;        end
            MS_A1: begin w_mul_c = w_a1;       w_mul_d = r_y1;        end
            MS_A2: begin w_mul_c = w_a2;       w_mul_d = r_y2;        end
            MS_GY: begin w_mul_c = i_cfg.gain; w_mul_d = r_y1;        end
            default: begin w_mul_c = '0;       w_mul_d = '0;          end
        endcase
    end

    assign w_prod = w_mul_c * w_mul_d;

    // round half up, drop 14 fraction bits, add offset, clip
    assign w_prod_rnd   = r_prod + ROUND_HALF_P;
    assign w_scaled_sum = {w_prod_rnd[PROD_W-1], w_prod_rnd[PROD_W-1:FRAC_BITS]}
                        + {{5{i_cfg.level_offset[SAMPLE_W-1]}}, i_cfg.level_offset};
    assign w_scaled     = sat16({{3{w_scaled_sum[20]}}, w_scaled_sum});

    assign w_acc_rnd = r_acc + ROUND_HALF_A;
    assign w_ysat    = sat16(w_acc_rnd[ACC_W-1:FRAC_BITS]);

    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_en) begin
            r_prod <= w_prod;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= w_prod_ext;
            ACC_ADD:  r_acc <= r_acc + w_prod_ext;
            ACC_SUB:  r_acc <= r_acc - w_prod_ext;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.scale_in) begin
            r_xs <= w_scaled.val;
        end
        if (i_cmd.scale_out) begin
            r_sample_out <= w_scaled.val;
            r_out_ovf    <= r_ovf | w_scaled.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1  <= '0;
            r_x2  <= '0;
            r_y1  <= '0;
            r_y2  <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (i_cmd.clr_ovf) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.scale_in) begin
                r_ovf <= r_ovf | w_scaled.ovf;
            end else if (i_cmd.update_hist) begin
                r_ovf <= r_ovf | w_ysat.ovf;
            end
            if (i_cmd.update_hist) begin
                r_x2 <= r_x1;
                r_x1 <= r_xs;
                r_y2 <= r_y1;
                r_y1 <= w_ysat.val;
            end
        end
    end

    assign o_sample_out = r_sample_out;
    assign o_overflow   = r_out_ovf;

endmodule

@@ rtl/direct_form_iir_biquad_top.sv @@
// Channel    Signals                                      Direction
// input      i_valid, o_ready, i_sample_in                request in
// output     o_valid, i_ready, o_sample_out, o_overflow   request out
// config     i_cfg_we, i_cfg_idx, i_cfg_data              write only
//
// A request steps through the states XS, B0, B2, A1, A2, LAST, Y, GY and OUT to a
// loaded result register; the next is taken only once the sequencer is back in IDLE,
// since the single 18x16 multiplier serves all seven products in turn.
// o_ready is high only while the sequencer is idle; a new request is taken while
// the previous result still waits in the output register.
// If that result is not taken by the end of the next request, the sequencer stalls.
// Reset is synchronous, active low; it restores register defaults and clears history.
module direct_form_iir_biquad_top
    import dfib_pkg::*;
#(
    parameter int unsigned TAP_COUNT = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    output logic                        o_overflow,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [COEF_W-1:0]           i_cfg_data
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    dfib_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    dfib_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    dfib_dp #(
        .TAP_COUNT (TAP_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out),
        .o_overflow   (o_overflow)
    );

endmodule

@@ rtl/dfib_chk.sv @@
`include "direct_form_iir_biquad_top_macros.svh"

module dfib_chk
    import dfib_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic signed [SAMPLE_W-1:0] o_sample_out,
    input logic                       o_overflow
);

    `DFIB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "block still ready after accepting a request")

    `DFIB_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_valid && o_ready, !$rose(o_valid), "result appeared one cycle after a request")

    `DFIB_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_valid), !$past(o_ready), "result appeared while the block was idle")

    `DFIB_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sample_out) && $stable(o_overflow), "stalled result changed")

endmodule

bind direct_form_iir_biquad_top dfib_chk u_dfib_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sample_out (o_sample_out),
    .o_overflow   (o_overflow)
);
